FILE: src/esrm_pkg.sv
// Shared types and codes of the error-statistics refinement marker.
`timescale 1ns / 1ps
package esrm_pkg;

    // Fixed field widths of the external interface.
    localparam int unsigned ERR_FIELD_W = 24;
    localparam int unsigned IDX_FIELD_W = 6;
    localparam int unsigned ACT_W       = 2;

    // Action codes of a result.
    localparam logic [ACT_W-1:0] ACT_KEEP    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REFINE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COARSEN = 2'd2;

    // Step counts.
    localparam logic [1:0] STEPS_NONE = 2'd0;
    localparam logic [1:0] STEPS_ONE  = 2'd1;
    localparam logic [1:0] STEPS_TWO  = 2'd2;

    // One loaded element as it waits in the input queue.
    typedef struct packed {
        logic [ERR_FIELD_W-1:0] err;
        logic                   last;
    } t_item;

    // One result as it waits in the output register.
    typedef struct packed {
        logic [IDX_FIELD_W-1:0] index;
        logic [ACT_W-1:0]       action;
        logic [1:0]             steps;
        logic                   any;
        logic                   last;
    } t_result;

endpackage

FILE: src/esrm_in_queue.sv
// Two-entry input queue that decouples loading from the statistics engine.
`timescale 1ns / 1ps
module esrm_in_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  esrm_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output esrm_pkg::t_item o_item
);

    esrm_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Storage is written without reset; pointers and fill level are cleared.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

FILE: src/esrm_divider.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module esrm_divider #(
    parameter int unsigned DW = 60,
    parameter int unsigned VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    localparam int unsigned CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    r_rem;
    logic [DW-1:0]    r_q;
    logic [VW-1:0]    r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [VW:0]      w_trial;
    logic             w_fits;

    assign w_trial    = {r_rem, r_q[DW-1]};
    assign w_fits     = (w_trial >= {1'b0, r_d});
    assign o_busy     = r_busy;
    assign o_quotient = r_q;

    // Datapath: bring down one dividend bit and subtract where it fits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= VW'(w_trial - {1'b0, r_d});
            end else begin
                r_rem <= w_trial[VW-1:0];
            end
            r_q <= {r_q[DW-2:0], w_fits};
        end
    end

    // Control: run for exactly DW steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

FILE: src/esrm_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module esrm_isqrt #(
    parameter int unsigned SW = 56
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SW-1:0]    i_value,
    output logic             o_busy,
    output logic [SW/2-1:0]  o_root
);

    localparam int unsigned HW    = SW / 2;
    localparam int unsigned CNT_W = $clog2(HW + 1);

    logic [HW:0]      r_rem;
    logic [HW-1:0]    r_root;
    logic [SW-1:0]    r_val;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [HW+2:0]    w_rem2;
    logic [HW+2:0]    w_trial;
    logic             w_fits;

    assign w_rem2  = {r_rem, r_val[SW-1:SW-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_fits  = (w_rem2 >= w_trial);
    assign o_busy  = r_busy;
    assign o_root  = r_root;

    // Datapath: take two radicand bits per step and try the next root bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_val  <= i_value;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= (HW + 1)'(w_rem2 - w_trial);
            end else begin
                r_rem <= w_rem2[HW:0];
            end
            r_root <= {r_root[HW-2:0], w_fits};
            r_val  <= {r_val[SW-3:0], 2'b00};
        end
    end

    // Control: run for HW steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(HW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

FILE: src/esrm_back.sv
// Back end: accumulation, statistics sequencer, element store and result emission.
`timescale 1ns / 1ps
module esrm_back #(
    parameter int unsigned MAX_ELEMENTS = 64,
    parameter int unsigned EW           = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  esrm_pkg::t_item                   i_q_item,
    output logic                              o_q_pop,
    input  logic [esrm_pkg::ERR_FIELD_W-1:0] i_thr,
    input  logic                              i_out_pop,
    output logic                              o_out_valid,
    output esrm_pkg::t_result                 o_out
);

    localparam int unsigned CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned AW    = $clog2(MAX_ELEMENTS);
    localparam int unsigned SUM_W = EW + CW;
    localparam int unsigned SQ_W  = 2 * EW + CW;
    localparam int unsigned PW    = 2 * SUM_W;
    localparam int unsigned SQE   = SQ_W + (SQ_W % 2);
    localparam int unsigned RW    = SQE / 2;
    localparam int unsigned SC_W  = $clog2(SUM_W + 1);
    localparam int unsigned TW    = esrm_pkg::ERR_FIELD_W;

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_ACC   = 11'b00000000010,
        S_DMEAN = 11'b00000000100,
        S_SQR   = 11'b00000001000,
        S_DSQ   = 11'b00000010000,
        S_DVAR  = 11'b00000100000,
        S_ROOT  = 11'b00001000000,
        S_SCRD  = 11'b00010000000,
        S_SCCK  = 11'b00100000000,
        S_EMRD  = 11'b01000000000,
        S_EMWR  = 11'b10000000000
    } t_state;

    t_state            r_state;
    t_state            n_state;

    // Element store, no reset: only entries of the current run are read.
    logic [EW-1:0]     r_mem [MAX_ELEMENTS];
    logic [EW-1:0]     r_rd_data;

    logic [CW-1:0]     r_count;
    logic [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_sqsum;
    logic [EW-1:0]     r_err;
    logic [2*EW-1:0]   r_sq;
    logic              r_store_ok;
    logic              r_last;
    logic              r_go;
    logic [PW-1:0]     r_div_a;
    logic [CW-1:0]     r_div_b;
    logic [EW-1:0]     r_mean;
    logic [PW-1:0]     r_sh_a;
    logic [SUM_W-1:0]  r_sh_b;
    logic [PW-1:0]     r_prod;
    logic [SC_W-1:0]   r_scnt;
    logic [SQE-1:0]    r_root_in;
    logic [RW:0]       r_lim;
    logic [CW-1:0]     r_k;
    logic              r_any;
    logic              r_out_v;
    esrm_pkg::t_result r_out;

    logic              w_div_busy;
    logic [PW-1:0]     w_div_q;
    logic              w_sqrt_busy;
    logic [RW-1:0]     w_root;
    logic [SUM_W-1:0]  w_sum_next;
    logic [CW-1:0]     w_count_next;
    logic [PW-1:0]     w_prod_next;
    logic [PW-1:0]     w_sqsum_ext;
    logic              w_last_k;
    logic              w_slot_free;
    logic [TW-1:0]     w_e;
    logic [TW+6:0]     w_thr100;
    logic [esrm_pkg::ACT_W-1:0] w_act;
    logic [1:0]        w_steps;

    assign o_q_pop      = (r_state == S_LOAD) && i_q_valid;
    assign o_out_valid  = r_out_v;
    assign o_out        = r_out;
    assign w_sum_next   = r_store_ok ? r_sum + SUM_W'(r_err) : r_sum;
    assign w_count_next = r_store_ok ? r_count + CW'(1) : r_count;
    assign w_prod_next  = r_sh_b[0] ? r_prod + r_sh_a : r_prod;
    assign w_sqsum_ext  = PW'(r_sqsum);
    assign w_last_k     = (r_k + CW'(1) == r_count);
    assign w_slot_free  = !r_out_v || i_out_pop;
    assign w_e          = TW'(r_rd_data);
    assign w_thr100     = {1'b0, i_thr, 6'b0} + {2'b0, i_thr, 5'b0} + {5'b0, i_thr, 2'b0};

    // Shared serial divider and square root unit.
    esrm_divider #(.DW(PW), .VW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go && (r_state == S_DMEAN || r_state == S_DSQ
                              || r_state == S_DVAR)),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_busy     (w_div_busy),
        .o_quotient (w_div_q)
    );

    esrm_isqrt #(.SW(SQE)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == S_ROOT)),
        .i_value (r_root_in),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    // Classify the element just read from the store.
    always_comb begin
        if (RW'(r_rd_data) > RW'(r_mean)) begin
            w_act   = esrm_pkg::ACT_REFINE;
            w_steps = ((RW + 1)'(r_rd_data) > r_lim) ? esrm_pkg::STEPS_TWO
                                                     : esrm_pkg::STEPS_ONE;
        end else if (w_e < i_thr) begin
            w_act   = esrm_pkg::ACT_COARSEN;
            w_steps = ((TW + 7)'(w_e) < w_thr100) ? esrm_pkg::STEPS_TWO
                                                  : esrm_pkg::STEPS_ONE;
        end else begin
            w_act   = esrm_pkg::ACT_KEEP;
            w_steps = esrm_pkg::STEPS_NONE;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (i_q_valid) n_state = S_ACC;
            S_ACC:   n_state = r_last ? S_DMEAN : S_LOAD;
            S_DMEAN: begin
                if (!r_go && !w_div_busy) begin
                    n_state = (r_count == CW'(1)) ? S_SCRD : S_SQR;
                end
            end
            S_SQR:   if (r_scnt == SC_W'(SUM_W - 1)) n_state = S_DSQ;
            S_DSQ: begin
                if (!r_go && !w_div_busy) begin
                    n_state = (w_sqsum_ext > w_div_q) ? S_DVAR : S_SCRD;
                end
            end
            S_DVAR:  if (!r_go && !w_div_busy) n_state = S_ROOT;
            S_ROOT:  if (!r_go && !w_sqrt_busy) n_state = S_SCRD;
            S_SCRD:  n_state = S_SCCK;
            S_SCCK:  n_state = w_last_k ? S_EMRD : S_SCRD;
            S_EMRD:  n_state = S_EMWR;
            S_EMWR: begin
                if (w_slot_free) begin
                    n_state = w_last_k ? S_LOAD : S_EMRD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Store write on load and registered read at the sweep index.
    always_ff @(posedge i_clk) begin
        if (o_q_pop && (r_count < CW'(MAX_ELEMENTS))) begin
            r_mem[r_count[AW-1:0]] <= i_q_item.err[EW-1:0];
        end
        r_rd_data <= r_mem[r_k[AW-1:0]];
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_err      <= i_q_item.err[EW-1:0];
                r_sq       <= i_q_item.err[EW-1:0] * i_q_item.err[EW-1:0];
                r_store_ok <= (r_count < CW'(MAX_ELEMENTS));
                r_last     <= i_q_item.last;
            end
            S_ACC: begin
                r_div_a <= PW'(w_sum_next);
                r_div_b <= w_count_next;
            end
            S_DMEAN: begin
                r_mean <= w_div_q[EW-1:0];
                r_lim  <= (RW + 1)'(w_div_q[EW-1:0]);
                r_sh_a <= PW'(r_sum);
                r_sh_b <= r_sum;
                r_prod <= '0;
                r_scnt <= '0;
            end
            S_SQR: begin
                r_prod  <= w_prod_next;
                r_sh_a  <= {r_sh_a[PW-2:0], 1'b0};
                r_sh_b  <= {1'b0, r_sh_b[SUM_W-1:1]};
                r_scnt  <= r_scnt + SC_W'(1);
                r_div_a <= w_prod_next;
            end
            S_DSQ: begin
                r_div_a <= w_sqsum_ext - w_div_q;
                r_div_b <= r_count - CW'(1);
            end
            S_DVAR: begin
                r_root_in <= SQE'(w_div_q[SQ_W-1:0]);
            end
            S_ROOT: begin
                r_lim <= (RW + 1)'(r_mean) + (RW + 1)'(w_root);
            end
            S_EMWR: begin
                if (w_slot_free) begin
                    r_out.index  <= esrm_pkg::IDX_FIELD_W'(r_k);
                    r_out.action <= w_act;
                    r_out.steps  <= w_steps;
                    r_out.any    <= r_any;
                    r_out.last   <= w_last_k;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers: state, run totals, sweep index and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_sum   <= '0;
            r_sqsum <= '0;
            r_go    <= 1'b0;
            r_k     <= '0;
            r_any   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= 1'b0;
            if (r_out_v && i_out_pop) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_ACC: begin
                    r_sum   <= w_sum_next;
                    r_sqsum <= r_store_ok ? r_sqsum + SQ_W'(r_sq) : r_sqsum;
                    r_count <= w_count_next;
                    r_go    <= r_last;
                end
                S_DMEAN: begin
                    r_k   <= '0;
                    r_any <= 1'b0;
                end
                S_SQR: begin
                    r_go <= (r_scnt == SC_W'(SUM_W - 1));
                end
                S_DSQ, S_DVAR: begin
                    r_go <= (n_state == S_DVAR || n_state == S_ROOT)
                            && (n_state != r_state);
                end
                S_SCCK: begin
                    if (w_act != esrm_pkg::ACT_KEEP) begin
                        r_any <= 1'b1;
                    end
                    r_k <= w_last_k ? '0 : r_k + CW'(1);
                end
                S_EMWR: begin
                    if (w_slot_free) begin
                        r_out_v <= 1'b1;
                        if (w_last_k) begin
                            r_k     <= '0;
                            r_count <= '0;
                            r_sum   <= '0;
                            r_sqsum <= '0;
                        end else begin
                            r_k <= r_k + CW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The run never holds more elements than the store can take.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("element count beyond store depth");

    // A new result only appears from the emission step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_state == S_EMWR))
        else $error("result loaded outside emission");

    // The divider is only started when it is idle.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_go && (r_state == S_DMEAN || r_state == S_DSQ || r_state == S_DVAR))
        |-> !w_div_busy)
        else $error("divider restarted while busy");

    // The final result of a run leaves the block back in the loading state.
    a_last_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_v) && r_out.last) |-> (r_state == S_LOAD && r_count == '0))
        else $error("run not cleared after final result");
`endif

endmodule

FILE: src/error_statistics_refinement_marker.sv
// Top level of the error-statistics refinement marker.
//
// Channel   | Direction | Handshake              | Payload
// input     | in        | push / full            | i_error_value, i_last_element
// result    | out       | empty / pop            | o_element_index .. o_last_result
// config    | in        | i_cfg_valid/o_cfg_ready| i_cfg_coarsen_threshold
//
// Each element passes a load and an accumulate state; a two-entry queue
// in front absorbs back-to-back pushes. After the last element the shared
// serial divider runs up to three times, with the squaring step between the
// first two divisions and the square root after the third.
// A marking sweep then reads and checks each element of the store, followed by
// emission of one result per element, stalling while the output slot is full.
// Reset is synchronous and active low; the store has no clearing pass.
`timescale 1ns / 1ps
module error_statistics_refinement_marker #(
    parameter int unsigned MAX_ELEMENTS = 64,
    parameter int unsigned ERROR_BITS   = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [23:0] i_error_value,
    input  logic        i_last_element,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_element_index,
    output logic [1:0]  o_action,
    output logic [1:0]  o_step_count,
    output logic        o_any_marked,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_coarsen_threshold
);

    localparam int unsigned EW = (ERROR_BITS < esrm_pkg::ERR_FIELD_W) ? ERROR_BITS
                                                                      : esrm_pkg::ERR_FIELD_W;

    logic [esrm_pkg::ERR_FIELD_W-1:0] r_thr;
    esrm_pkg::t_item                  w_in_item;
    esrm_pkg::t_item                  w_q_item;
    esrm_pkg::t_result                w_out;
    logic                             w_q_valid;
    logic                             w_q_pop;
    logic                             w_out_valid;

    // Coarsen threshold register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= esrm_pkg::ERR_FIELD_W'(1);
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_coarsen_threshold;
        end
    end

    // Mask the error to the configured width before it is queued.
    assign w_in_item.err  = esrm_pkg::ERR_FIELD_W'(i_error_value[EW-1:0]);
    assign w_in_item.last = i_last_element;

    esrm_in_queue u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (w_in_item),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    esrm_back #(.MAX_ELEMENTS(MAX_ELEMENTS), .EW(EW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .i_thr       (r_thr),
        .i_out_pop   (pop),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    // Result ports.
    assign empty           = !w_out_valid;
    assign o_element_index = w_out.index;
    assign o_action        = w_out.action;
    assign o_step_count    = w_out.steps;
    assign o_any_marked    = w_out.any;
    assign o_last_result   = w_out.last;

endmodule
